// ----- sv/gpr_pkg.sv -----
`timescale 1ns / 1ps

package gpr_pkg;

    localparam int CELL_COLS  = 6;
    localparam int CELL_ROWS  = 8;
    localparam int GLYPH_COLS = 5;

    localparam logic [7:0] FIRST_CODE  = 8'h20;
    localparam logic [7:0] LAST_CODE   = 8'h7E;
    localparam logic [9:0] COORD_LIMIT = 10'd512;

    localparam logic [9:0] WIDTH_RESET  = 10'd240;
    localparam logic [9:0] HEIGHT_RESET = 10'd320;

    // configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [8:0]  origin_x;
        logic [8:0]  origin_y;
        logic [7:0]  char_code;
        logic [15:0] fore_color;
        logic [15:0] back_color;
    } pixel_in_t;

    typedef struct packed {
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [15:0] pixel_color;
        logic        last_pixel;
    } pixel_out_t;

    // classified character, ready to draw
    typedef struct packed {
        logic [8:0]  origin_x;
        logic [8:0]  origin_y;
        logic [6:0]  glyph;
        logic [15:0] fore_color;
        logic [15:0] back_color;
        logic [2:0]  last_col;
        logic [2:0]  last_row;
    } draw_cmd_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } queue_status_t;

    typedef logic [0:GLYPH_COLS-1][6:0] glyph_cols_t;

    // column bitmap of a glyph column; bit r is row r, columns past the glyph are blank
    function automatic logic [7:0] glyph_bits(input logic [6:0] glyph, input logic [2:0] col);
        glyph_cols_t cols;
        logic [7:0]  bits;
        case (glyph)
            7'd0:  cols = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
            7'd1:  cols = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
            7'd2:  cols = {7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
            7'd3:  cols = {7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
            7'd4:  cols = {7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12};
            7'd5:  cols = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
            7'd6:  cols = {7'h36, 7'h49, 7'h55, 7'h22, 7'h50};
            7'd7:  cols = {7'h00, 7'h05, 7'h03, 7'h00, 7'h00};
            7'd8:  cols = {7'h00, 7'h1C, 7'h22, 7'h41, 7'h00};
            7'd9:  cols = {7'h00, 7'h41, 7'h22, 7'h1C, 7'h00};
            7'd10: cols = {7'h14, 7'h08, 7'h3E, 7'h08, 7'h14};
            7'd11: cols = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
            7'd12: cols = {7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
            7'd13: cols = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
            7'd14: cols = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
            7'd15: cols = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
            7'd16: cols = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
            7'd17: cols = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
            7'd18: cols = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
            7'd19: cols = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
            7'd20: cols = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
            7'd21: cols = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
            7'd22: cols = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
            7'd23: cols = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
            7'd24: cols = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            7'd25: cols = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
            7'd26: cols = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
            7'd27: cols = {7'h00, 7'h56, 7'h36, 7'h00, 7'h00};
            7'd28: cols = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
            7'd29: cols = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
            7'd30: cols = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
            7'd31: cols = {7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
            7'd32: cols = {7'h32, 7'h49, 7'h79, 7'h41, 7'h3E};
            7'd33: cols = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
            7'd34: cols = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
            7'd35: cols = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
            7'd36: cols = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
            7'd37: cols = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
            7'd38: cols = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
            7'd39: cols = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
            7'd40: cols = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            7'd41: cols = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            7'd42: cols = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
            7'd43: cols = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
            7'd44: cols = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
            7'd45: cols = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
            7'd46: cols = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
            7'd47: cols = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            7'd48: cols = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
            7'd49: cols = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
            7'd50: cols = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
            7'd51: cols = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            7'd52: cols = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            7'd53: cols = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
            7'd54: cols = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            7'd55: cols = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
            7'd56: cols = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
            7'd57: cols = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
            7'd58: cols = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
            7'd59: cols = {7'h00, 7'h7F, 7'h41, 7'h41, 7'h00};
            7'd60: cols = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
            7'd61: cols = {7'h00, 7'h41, 7'h41, 7'h7F, 7'h00};
            7'd62: cols = {7'h04, 7'h02, 7'h01, 7'h02, 7'h04};
            7'd63: cols = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
            7'd64: cols = {7'h00, 7'h01, 7'h02, 7'h04, 7'h00};
            7'd65: cols = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
            7'd66: cols = {7'h7F, 7'h48, 7'h44, 7'h44, 7'h38};
            7'd67: cols = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
            7'd68: cols = {7'h38, 7'h44, 7'h44, 7'h48, 7'h7F};
            7'd69: cols = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
            7'd70: cols = {7'h08, 7'h7E, 7'h09, 7'h01, 7'h02};
            7'd71: cols = {7'h0C, 7'h52, 7'h52, 7'h52, 7'h3E};
            7'd72: cols = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
            7'd73: cols = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
            7'd74: cols = {7'h20, 7'h40, 7'h44, 7'h3D, 7'h00};
            7'd75: cols = {7'h7F, 7'h10, 7'h28, 7'h44, 7'h00};
            7'd76: cols = {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
            7'd77: cols = {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
            7'd78: cols = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
            7'd79: cols = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
            7'd80: cols = {7'h7C, 7'h14, 7'h14, 7'h14, 7'h08};
            7'd81: cols = {7'h08, 7'h14, 7'h14, 7'h18, 7'h7C};
            7'd82: cols = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
            7'd83: cols = {7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
            7'd84: cols = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
            7'd85: cols = {7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C};
            7'd86: cols = {7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C};
            7'd87: cols = {7'h3C, 7'h40, 7'h30, 7'h40, 7'h3C};
            7'd88: cols = {7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
            7'd89: cols = {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
            7'd90: cols = {7'h44, 7'h64, 7'h54, 7'h4C, 7'h44};
            7'd91: cols = {7'h00, 7'h08, 7'h36, 7'h41, 7'h00};
            7'd92: cols = {7'h00, 7'h00, 7'h7F, 7'h00, 7'h00};
            7'd93: cols = {7'h00, 7'h41, 7'h36, 7'h08, 7'h00};
            7'd94: cols = {7'h08, 7'h08, 7'h2A, 7'h1C, 7'h08};
            default: cols = '0;
        endcase
        if (col < 3'(GLYPH_COLS))
        begin
            bits = {1'b0, cols[col]};
        end
        else
        begin
            bits = '0;
        end
        return bits;
    endfunction

endpackage

// ----- sv/gpr_front.sv -----
`timescale 1ns / 1ps

module gpr_front
    import gpr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [9:0]    cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  pixel_in_t     in_data,
    input  queue_status_t queue_status,
    output logic          push,
    output draw_cmd_t     push_cmd
);

    logic [9:0] screen_width_reg;
    logic [9:0] screen_height_reg;
    logic [9:0] wlim;
    logic [9:0] hlim;
    logic [9:0] room_x;
    logic [9:0] room_y;
    logic       visible;
    logic       printable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        wlim = (screen_width_reg > COORD_LIMIT) ? COORD_LIMIT : screen_width_reg;
        hlim = (screen_height_reg > COORD_LIMIT) ? COORD_LIMIT : screen_height_reg;
        visible = ({1'b0, in_data.origin_x} < wlim) && ({1'b0, in_data.origin_y} < hlim);
        // pixels left before the right and bottom edges
        room_x = wlim - {1'b0, in_data.origin_x};
        room_y = hlim - {1'b0, in_data.origin_y};
        printable = (in_data.char_code >= FIRST_CODE) && (in_data.char_code <= LAST_CODE);

        push_cmd.origin_x   = in_data.origin_x;
        push_cmd.origin_y   = in_data.origin_y;
        push_cmd.glyph      = printable ? 7'(in_data.char_code - FIRST_CODE) : '0;
        push_cmd.fore_color = in_data.fore_color;
        push_cmd.back_color = in_data.back_color;
        push_cmd.last_col   = (room_x >= 10'(CELL_COLS)) ? 3'(CELL_COLS - 1) : 3'(room_x - 10'd1);
        push_cmd.last_row   = (room_y >= 10'(CELL_ROWS)) ? 3'(CELL_ROWS - 1) : 3'(room_y - 10'd1);
    end

    // off-screen items are taken and dropped
    assign in_ready = queue_status.not_full;
    assign push     = in_valid && in_ready && visible;

endmodule

// ----- sv/gpr_queue.sv -----
`timescale 1ns / 1ps

module gpr_queue
    import gpr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  draw_cmd_t     push_cmd,
    input  logic          pop,
    output draw_cmd_t     head_cmd,
    output queue_status_t status
);

    draw_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd         = entry_reg[rd_ptr_reg];
    assign status.not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);

endmodule

// ----- sv/gpr_back.sv -----
`timescale 1ns / 1ps

module gpr_back
    import gpr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t queue_status,
    input  draw_cmd_t     head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output pixel_out_t    out_data
);

    logic [2:0]  col_reg;
    logic [2:0]  col_next;
    logic [2:0]  row_reg;
    logic [2:0]  row_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    pixel_out_t  out_data_reg;
    pixel_out_t  pixel;
    logic [7:0]  bits;
    logic        advance;
    logic        emit;
    logic        last;

    assign advance = !out_valid_reg || out_ready;
    assign emit    = advance && queue_status.not_empty;
    assign last    = (col_reg == head_cmd.last_col) && (row_reg == head_cmd.last_row);
    assign pop     = emit && last;

    always_comb
    begin
        // bit 7 is the blank bottom row; the sixth column reads as all clear
        bits = glyph_bits(head_cmd.glyph, col_reg);
        pixel.pixel_x     = head_cmd.origin_x + 9'(col_reg);
        pixel.pixel_y     = head_cmd.origin_y + 9'(row_reg);
        pixel.pixel_color = bits[row_reg] ? head_cmd.fore_color : head_cmd.back_color;
        pixel.last_pixel  = last;

        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = queue_status.not_empty;
        end
        if (emit)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_reg == head_cmd.last_row)
            begin
                col_next = col_reg + 1'b1;
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= pixel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/glyph_pixel_renderer.sv -----
`timescale 1ns / 1ps
// 5x7 character renderer producing a stream of RGB565 pixel writes.
// Input channel (in_valid/in_ready/in_data): one character with the top-left
// corner of its 6x8 cell and foreground/background colors.
// Output channel (out_valid/out_ready/out_data): one pixel write per visible
// pixel, column by column, rows top to bottom inside a column; last_pixel
// marks the final write of a character. Off-screen characters give nothing.
// Config port (cfg_we/cfg_index/cfg_data): index 0 screen width, index 1
// screen height; reset values 240 and 320.
// An accepted character is stored in the queue; its pixels then pass the output register.
// Throughput: one pixel per cycle while out_ready is high; a character gives one
// write per visible pixel (up to 48); the back end's single output register sets
// this rate. A two-entry command queue lets the next characters be taken while
// the current one draws, and consecutive characters follow without a gap.
// When out_ready is low with a pixel held, the output register keeps it and the drawing
// counters stop; input keeps being taken until the queue is full.
// Reset clears the queue, counters and output valid, and restores the screen
// size registers.

module glyph_pixel_renderer
    import gpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  pixel_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_out_t out_data
);

    queue_status_t queue_status;
    draw_cmd_t     push_cmd;
    draw_cmd_t     head_cmd;
    logic          push;
    logic          pop;

    gpr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .queue_status (queue_status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    gpr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (queue_status)
    );

    gpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
